/* hdl/rsc_enc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Recursive systematic encoder package
// Shared widths, register indexes, reset values and the configuration type.
// ----------------------------------------------------------------------------
package rsc_enc_pkg;

   localparam int SYMBOL_BITS    = 4;
   localparam int POLY_BITS      = 7;
   localparam int WIDTH_REG_BITS = 3;
   localparam int CSR_ADDR_BITS  = 3;
   localparam int CSR_DATA_BITS  = 7;
   localparam int REQ_DATA_BITS  = 8;
   localparam int RSP_DATA_BITS  = 8;

   localparam int DEF_STATE_BITS     = 6;
   localparam int DEF_MAX_INPUT_BITS = 4;

   localparam logic [CSR_ADDR_BITS-1:0] REG_INPUT_WIDTH   = 3'd0;
   localparam logic [CSR_ADDR_BITS-1:0] REG_FEEDBACK_POLY = 3'd1;
   localparam logic [CSR_ADDR_BITS-1:0] REG_FF_POLY_0     = 3'd2;
   localparam logic [CSR_ADDR_BITS-1:0] REG_FF_POLY_1     = 3'd3;
   localparam logic [CSR_ADDR_BITS-1:0] REG_FF_POLY_2     = 3'd4;
   localparam logic [CSR_ADDR_BITS-1:0] REG_FF_POLY_3     = 3'd5;

   localparam logic [WIDTH_REG_BITS-1:0] RST_INPUT_WIDTH   = 3'd1;
   localparam logic [POLY_BITS-1:0]      RST_FEEDBACK_POLY = 7'd103;
   localparam logic [POLY_BITS-1:0]      RST_FF_POLY_0     = 7'd93;
   localparam logic [POLY_BITS-1:0]      RST_FF_POLY_N     = 7'd0;

   typedef struct packed {
      logic [SYMBOL_BITS-1:0]                sym_mask;
      logic [POLY_BITS-1:0]                  feedback_poly;
      logic [SYMBOL_BITS-1:0][POLY_BITS-1:0] ff_poly;
   } cfg_type;

endpackage

/* hdl/rsc_enc_csr.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Recursive systematic encoder configuration registers
// Holds the width and polynomial registers and derives the symbol bit mask.
// ----------------------------------------------------------------------------
module rsc_enc_csr #(
   parameter int MAX_INPUT_BITS = rsc_enc_pkg::DEF_MAX_INPUT_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [rsc_enc_pkg::CSR_ADDR_BITS-1:0]  csr_addr,
   input  logic [rsc_enc_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output rsc_enc_pkg::cfg_type                   cfg
);

   localparam logic [rsc_enc_pkg::WIDTH_REG_BITS-1:0] MAX_K =
      rsc_enc_pkg::WIDTH_REG_BITS'(MAX_INPUT_BITS);

   logic [rsc_enc_pkg::WIDTH_REG_BITS-1:0] input_width_ff;
   logic [rsc_enc_pkg::POLY_BITS-1:0]      feedback_poly_ff;
   logic [rsc_enc_pkg::WIDTH_REG_BITS-1:0] k_eff;
   logic [rsc_enc_pkg::SYMBOL_BITS-1:0]    sym_mask;

   always_ff @(posedge clock) begin
      if (reset) begin
         input_width_ff   <= rsc_enc_pkg::RST_INPUT_WIDTH;
         feedback_poly_ff <= rsc_enc_pkg::RST_FEEDBACK_POLY;
      end else if (csr_we) begin
         if (csr_addr == rsc_enc_pkg::REG_INPUT_WIDTH) begin
            input_width_ff <= csr_wdata[rsc_enc_pkg::WIDTH_REG_BITS-1:0];
         end
         if (csr_addr == rsc_enc_pkg::REG_FEEDBACK_POLY) begin
            feedback_poly_ff <= csr_wdata;
         end
      end
   end

   for (genvar j = 0; j < rsc_enc_pkg::SYMBOL_BITS; j++) begin : g_ff
      if (j < MAX_INPUT_BITS) begin : g_reg
         localparam logic [rsc_enc_pkg::CSR_ADDR_BITS-1:0] ADDR =
            rsc_enc_pkg::REG_FF_POLY_0 + rsc_enc_pkg::CSR_ADDR_BITS'(j);
         logic [rsc_enc_pkg::POLY_BITS-1:0] poly_ff;

         always_ff @(posedge clock) begin
            if (reset) begin
               poly_ff <= (j == 0) ? rsc_enc_pkg::RST_FF_POLY_0
                                   : rsc_enc_pkg::RST_FF_POLY_N;
            end else if (csr_we && csr_addr == ADDR) begin
               poly_ff <= csr_wdata;
            end
         end
         assign cfg.ff_poly[j] = poly_ff;
      end else begin : g_none
         assign cfg.ff_poly[j] = '0;
      end
   end

   always_comb begin
      if (input_width_ff == '0) begin
         k_eff = rsc_enc_pkg::WIDTH_REG_BITS'(1);
      end else if (input_width_ff > MAX_K) begin
         k_eff = MAX_K;
      end else begin
         k_eff = input_width_ff;
      end
      for (int j = 0; j < rsc_enc_pkg::SYMBOL_BITS; j++) begin
         sym_mask[j] = (rsc_enc_pkg::WIDTH_REG_BITS'(j) < k_eff);
      end
   end

   assign cfg.sym_mask      = sym_mask;
   assign cfg.feedback_poly = feedback_poly_ff;

endmodule

/* hdl/rsc_enc_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Recursive systematic encoder datapath
// Encoder state, combinational parity update and the result register.
// ----------------------------------------------------------------------------
module rsc_enc_core #(
   parameter int STATE_BITS = rsc_enc_pkg::DEF_STATE_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  rsc_enc_pkg::cfg_type                  cfg,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  logic [rsc_enc_pkg::SYMBOL_BITS-1:0]   in_symbol,
   input  logic                                  in_last,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output logic                                  out_parity,
   output logic [rsc_enc_pkg::SYMBOL_BITS-1:0]   out_systematic,
   output logic                                  out_end_of_block,
   output logic                                  out_not_terminated
);

   localparam int PW = STATE_BITS + 1;

   logic [STATE_BITS-1:0] state_ff;
   logic [STATE_BITS-1:0] state_in;
   logic                  valid_ff;
   logic                  parity_ff;
   logic                  parity_in;
   logic [rsc_enc_pkg::SYMBOL_BITS-1:0] sys_ff;
   logic [rsc_enc_pkg::SYMBOL_BITS-1:0] sys_in;
   logic                  eob_ff;
   logic                  nterm_ff;
   logic                  nterm_in;
   logic                  accept;

   logic [rsc_enc_pkg::SYMBOL_BITS-1:0][PW-1:0] ff_ext;
   logic [PW-1:0]         fb_ext;
   logic [PW-1:0]         t_val;
   logic [PW-1:0]         r_val;
   logic [STATE_BITS-1:0] nxt;

   for (genvar i = 0; i < PW; i++) begin : g_ext
      if (i < rsc_enc_pkg::POLY_BITS) begin : g_bit
         assign fb_ext[i] = cfg.feedback_poly[i];
         for (genvar j = 0; j < rsc_enc_pkg::SYMBOL_BITS; j++) begin : g_j
            assign ff_ext[j][i] = cfg.ff_poly[j][i];
         end
      end else begin : g_zero
         assign fb_ext[i] = 1'b0;
         for (genvar j = 0; j < rsc_enc_pkg::SYMBOL_BITS; j++) begin : g_j
            assign ff_ext[j][i] = 1'b0;
         end
      end
   end

   always_comb begin
      sys_in = in_symbol & cfg.sym_mask;
      t_val  = {1'b0, state_ff};
      for (int j = 0; j < rsc_enc_pkg::SYMBOL_BITS; j++) begin
         if (sys_in[j]) begin
            t_val = t_val ^ ff_ext[j];
         end
      end
      parity_in = t_val[0];
      r_val     = parity_in ? (t_val ^ fb_ext) : t_val;
      nxt       = r_val[PW-1:1];
      nterm_in  = in_last && (nxt != '0);
      state_in  = in_last ? '0 : nxt;
   end

   assign in_ready = !valid_ff || out_ready;
   assign accept   = in_valid && in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         state_ff <= '0;
      end else begin
         if (in_ready) begin
            valid_ff <= in_valid;
         end
         if (accept) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         parity_ff <= parity_in;
         sys_ff    <= sys_in;
         eob_ff    <= in_last;
         nterm_ff  <= nterm_in;
      end
   end

   assign out_valid          = valid_ff;
   assign out_parity         = parity_ff;
   assign out_systematic     = sys_ff;
   assign out_end_of_block   = eob_ff;
   assign out_not_terminated = nterm_ff;

endmodule

/* hdl/recursive_systematic_conv_encoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Recursive systematic convolutional encoder
// Rate k/(k+1) encoder with a programmable feedback polynomial and up to four
// feed-forward polynomials, one symbol of k message bits per word.
// ----------------------------------------------------------------------------
// Each accepted word yields one result word in the next cycle, and a new word is
// taken every clock while the result side keeps up, so the throughput is one
// symbol per cycle. The state update is a single XOR pass from the encoder
// state register to the result register. A word marked last reports whether
// the final state is nonzero and returns the state to zero.
module recursive_systematic_conv_encoder #(
   parameter int STATE_BITS     = rsc_enc_pkg::DEF_STATE_BITS,
   parameter int MAX_INPUT_BITS = rsc_enc_pkg::DEF_MAX_INPUT_BITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // symbol[3:0], zero pad [7:4]
   input  logic [rsc_enc_pkg::REQ_DATA_BITS-1:0] req_tdata,
   input  logic                                  req_tlast,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // parity[0], systematic[4:1], zero pad [7:5]
   output logic [rsc_enc_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   // not_terminated[0]
   output logic                                  rsp_tuser,
   output logic                                  rsp_tlast,
   input  logic                                  csr_we,
   input  logic [rsc_enc_pkg::CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [rsc_enc_pkg::CSR_DATA_BITS-1:0] csr_wdata
);

   rsc_enc_pkg::cfg_type                cfg;
   logic                                parity;
   logic [rsc_enc_pkg::SYMBOL_BITS-1:0] systematic;

   rsc_enc_csr #(
      .MAX_INPUT_BITS (MAX_INPUT_BITS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rsc_enc_core #(
      .STATE_BITS (STATE_BITS)
   ) u_core (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .in_valid           (req_tvalid),
      .in_ready           (req_tready),
      .in_symbol          (req_tdata[rsc_enc_pkg::SYMBOL_BITS-1:0]),
      .in_last            (req_tlast),
      .out_valid          (rsp_tvalid),
      .out_ready          (rsp_tready),
      .out_parity         (parity),
      .out_systematic     (systematic),
      .out_end_of_block   (rsp_tlast),
      .out_not_terminated (rsp_tuser)
   );

   assign rsp_tdata = {{(rsc_enc_pkg::RSP_DATA_BITS - rsc_enc_pkg::SYMBOL_BITS - 1){1'b0}},
                       systematic, parity};

endmodule
